@@ sv/logocc_pkg.sv @@
package logocc_pkg;

  localparam int MaxCellsDef   = 65536;
  localparam int SineDepthDef  = 1024;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_CPM       = 3'd2,
    CFG_GRID_W    = 3'd3,
    CFG_GRID_H    = 3'd4,
    CFG_RANGE_MIN = 3'd5,
    CFG_RANGE_MAX = 3'd6
  } cfg_idx_e;

  localparam logic signed [11:0] LoHit   = 12'sd218;
  localparam logic signed [11:0] LoMiss  = -12'sd102;
  localparam logic signed [12:0] LoLimit = 13'sd1280;
  localparam logic [11:0] LoUnknown = 12'd2;

  localparam int NumLogit = 49;

  function automatic logic [10:0] logit_floor(input logic [5:0] j);
    logic [10:0] v;
    unique case (j)
      6'd0: v = 11'd10;    6'd1: v = 11'd20;    6'd2: v = 11'd30;
      6'd3: v = 11'd41;    6'd4: v = 11'd51;    6'd5: v = 11'd61;
      6'd6: v = 11'd72;    6'd7: v = 11'd82;    6'd8: v = 11'd93;
      6'd9: v = 11'd103;   6'd10: v = 11'd114;  6'd11: v = 11'd125;
      6'd12: v = 11'd136;  6'd13: v = 11'd147;  6'd14: v = 11'd158;
      6'd15: v = 11'd169;  6'd16: v = 11'd181;  6'd17: v = 11'd192;
      6'd18: v = 11'd204;  6'd19: v = 11'd216;  6'd20: v = 11'd229;
      6'd21: v = 11'd241;  6'd22: v = 11'd254;  6'd23: v = 11'd267;
      6'd24: v = 11'd281;  6'd25: v = 11'd295;  6'd26: v = 11'd309;
      6'd27: v = 11'd324;  6'd28: v = 11'd339;  6'd29: v = 11'd354;
      6'd30: v = 11'd371;  6'd31: v = 11'd388;  6'd32: v = 11'd405;
      6'd33: v = 11'd424;  6'd34: v = 11'd444;  6'd35: v = 11'd464;
      6'd36: v = 11'd486;  6'd37: v = 11'd510;  6'd38: v = 11'd535;
      6'd39: v = 11'd562;  6'd40: v = 11'd592;  6'd41: v = 11'd625;
      6'd42: v = 11'd662;  6'd43: v = 11'd704;  6'd44: v = 11'd753;
      6'd45: v = 11'd813;  6'd46: v = 11'd889;  6'd47: v = 11'd996;
      6'd48: v = 11'd1176;
      default: v = 11'h7FF;
    endcase
    return v;
  endfunction

  // sine polynomial coefficients, Q15, Horner order
  function automatic logic signed [17:0] poly_coef(input logic [2:0] k);
    logic signed [17:0] c;
    unique case (k)
      3'd0: c = 18'sd5;
      3'd1: c = -18'sd153;
      3'd2: c = 18'sd2611;
      3'd3: c = -18'sd21167;
      3'd4: c = 18'sd51472;
      default: c = 18'sd0;
    endcase
    return c;
  endfunction

endpackage

@@ sv/log_odds_occupancy_grid_update.sv @@
// Log-odds occupancy grid update, one laser beam per input word.
//
// Input channel (in_valid_i / in_stall_o): robot pose, heading, beam angle
// and range. Output channel (out_valid_o / out_stall_i): one result word per
// beam: in-bounds flag, cell index, new clamped log-odds and occupancy.
// Configuration (cfg_we_i / cfg_idx_i / cfg_data_i) is to be written only
// while idle; the user is bound to this, the block does not enforce it.
// One shared 26x18 signed multiplier under a small sequencer does all the
// arithmetic. Each multiply has an issue step and a consume step. Per axis
// (cosine/x first, then sine/y): t*t, the polynomial multiplies, then the
// range product. Then cell scaling for both axes, row*width and a check.
// An out-of-grid beam then has its result word valid. An in-grid beam adds
// a store read, update and write-back and a threshold scan over the
// NumLogit thresholds for the occupancy before its result word is valid.
// in_stall_o stays high until the result word is taken; the next beam can
// be accepted in the cycle after that, so the block takes no new beam while
// one is in flight. A stalled output holds its word unchanged.
//
// After reset a clearing pass zeroes the store, one entry per cycle, during
// which no beam is accepted. SineDepth must be a power of two.
module log_odds_occupancy_grid_update
  import logocc_pkg::*;
#(
  parameter int MaxCells  = MaxCellsDef,
  parameter int SineDepth = SineDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [23:0]  robot_x_i,
  input  logic signed [23:0]  robot_y_i,
  input  logic [15:0]         heading_i,
  input  logic [15:0]         beam_angle_i,
  input  logic signed [23:0]  range_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                in_bounds_o,
  output logic [15:0]         cell_index_o,
  output logic signed [11:0]  log_odds_o,
  output logic signed [7:0]   occupancy_o
);

  localparam int AddrW = $clog2(MaxCells);
  localparam int SdW   = $clog2(SineDepth);
  localparam int IdxW  = 27;   // row*width+column before the store bound check
  // angle quantized to SineDepth steps per turn
  localparam logic [15:0] PhaseMask = 16'(32'hFFFF_FFFF << (16 - SdW));

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_TRIG  = 12'b000000000100,
    S_POLY  = 12'b000000001000,
    S_RANGE = 12'b000000010000,
    S_SCALE = 12'b000000100000,
    S_ROW   = 12'b000001000000,
    S_CHECK = 12'b000010000000,
    S_READ  = 12'b000100000000,
    S_UPD   = 12'b001000000000,
    S_SCAN  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic signed [23:0] org_x_q, org_y_q;
  logic [10:0] cpm_q;
  logic [12:0] gw_q, gh_q;
  logic [22:0] rmin_q, rmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      cpm_q   <= 11'd20;
      gw_q    <= '0;
      gh_q    <= '0;
      rmin_q  <= '0;
      rmax_q  <= 23'd8192;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_X:  org_x_q <= cfg_data_i;
        CFG_ORIGIN_Y:  org_y_q <= cfg_data_i;
        CFG_CPM:       cpm_q   <= cfg_data_i[10:0];
        CFG_GRID_W:    gw_q    <= cfg_data_i[12:0];
        CFG_GRID_H:    gh_q    <= cfg_data_i[12:0];
        CFG_RANGE_MIN: rmin_q  <= cfg_data_i[22:0];
        CFG_RANGE_MAX: rmax_q  <= cfg_data_i[22:0];
        default: ;
      endcase
    end
  end

  // shared multiplier: registered product
  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [43:0] prod_q;

  // working registers
  logic signed [23:0] rx_q, ry_q, rng_q;
  logic [15:0] ang_q;
  logic hit_q;
  logic axis_q;              // 0: cosine/x, 1: sine/y
  logic [2:0] step_q;        // sub-step counter within a phase
  logic phase_q;             // 0: issue multiply, 1: consume product
  logic [15:0] t_q;          // 2*r, up to 32768
  logic [15:0] t2_q;
  logic signed [17:0] acc_q;
  logic neg_q;
  logic signed [25:0] px_q, py_q;    // point minus origin
  logic signed [25:0] gx_q, gy_q;    // cell coordinates
  logic [IdxW-1:0] idx_q;
  logic ok_q;
  logic signed [11:0] lo_q;
  logic [10:0] mag_q;
  logic [5:0] cnt_q;
  logic [AddrW:0] clr_q;

  // quadrant handling for the current axis
  logic [15:0] ang_eff;
  logic [15:0] phase_p;
  logic [13:0] rem;
  logic [14:0] xarg;
  logic [15:0] t_cur;

  always_comb begin
    ang_eff = axis_q ? ang_q : ang_q + 16'd16384;
    phase_p = ang_eff & PhaseMask;
    rem     = phase_p[13:0];
    xarg    = phase_p[14] ? 15'd16384 - {1'b0, rem} : {1'b0, rem};
    t_cur   = {xarg, 1'b0};
  end

  function automatic logic signed [43:0] fshift(input logic signed [43:0] v,
                                                input logic [4:0] n);
    return v >>> n;
  endfunction

  logic signed [43:0] sh16;
  logic signed [15:0] trig_val;
  logic signed [43:0] offs;
  logic signed [25:0] pnt;
  logic signed [43:0] cell_div;
  logic [IdxW-1:0] idx_sum;
  logic in_grid;
  logic signed [12:0] lo_sum;
  logic signed [11:0] lo_clamp;
  logic [11:0] lo_mag;
  logic [11:0] rd_data;
  logic signed [11:0] store_lo;
  logic ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [11:0] ram_wdata;
  logic in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    sh16     = fshift(prod_q, 5'd16);
    trig_val = neg_q ? -16'(acc_q) : 16'(acc_q);
    offs     = hit_q ? fshift(prod_q, 5'd14) : fshift(prod_q, 5'd15);
    pnt      = 26'(axis_q ? ry_q : rx_q) + 26'(offs);
    // truncation toward zero of product / 1024
    cell_div = (prod_q < 0) ? -((-prod_q) >>> 10) : (prod_q >>> 10);
    idx_sum  = prod_q[IdxW-1:0] + IdxW'(gx_q[12:0]);
    in_grid  = !gx_q[25] && !gy_q[25] && (gx_q[24:0] < 25'(gw_q)) &&
               (gy_q[24:0] < 25'(gh_q));
    store_lo = rd_data;
    lo_sum   = 13'(store_lo) + 13'(hit_q ? LoHit : LoMiss);
    if (lo_sum > LoLimit) lo_clamp = 12'(LoLimit);
    else if (lo_sum < -LoLimit) lo_clamp = 12'(-LoLimit);
    else lo_clamp = 12'(lo_sum);
    lo_mag = lo_clamp[11] ? 12'(-lo_clamp) : 12'(lo_clamp);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_TRIG: begin
        mul_a = 26'($signed({1'b0, t_cur}));
        mul_b = 18'($signed({1'b0, t_cur}));
      end
      S_POLY: begin
        mul_a = 26'(acc_q);
        mul_b = (step_q == 3'd4) ? 18'($signed({1'b0, t_q})) :
                                   18'($signed({1'b0, t2_q}));
      end
      S_RANGE: begin
        mul_a = 26'(rng_q);
        mul_b = 18'(trig_val);
      end
      S_SCALE: begin
        mul_a = axis_q ? py_q : px_q;
        mul_b = 18'($signed({1'b0, cpm_q}));
      end
      S_ROW: begin
        mul_a = gy_q;
        mul_b = 18'($signed({1'b0, gw_q}));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  logic [AddrW:0] clr_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == (AddrW+1)'(MaxCells - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = S_TRIG;
      S_TRIG:  if (phase_q) state_d = S_POLY;
      S_POLY:  if (phase_q && step_q == 3'd4) state_d = S_RANGE;
      S_RANGE: if (phase_q) state_d = axis_q ? S_SCALE : S_TRIG;
      S_SCALE: if (phase_q && axis_q) state_d = S_ROW;
      S_ROW:   if (phase_q) state_d = S_CHECK;
      S_CHECK: state_d = ok_q ? S_READ : S_OUT;
      S_READ:  state_d = S_UPD;
      S_UPD:   state_d = S_SCAN;
      S_SCAN:  if (cnt_q == 6'(NumLogit - 1)) state_d = S_OUT;
      S_OUT:   if (out_acc) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign clr_d = clr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      phase_q <= 1'b0;
      step_q  <= '0;
      axis_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_d;
      unique case (state_q)
        S_IDLE: begin
          phase_q <= 1'b0;
          step_q  <= '0;
          axis_q  <= 1'b0;
        end
        S_TRIG, S_ROW: phase_q <= ~phase_q;
        S_POLY: begin
          phase_q <= ~phase_q;
          if (phase_q) step_q <= (step_q == 3'd4) ? 3'd0 : step_q + 3'd1;
        end
        // in RANGE the x pass returns to TRIG for y; in both the y pass moves on with axis back at x
        S_RANGE, S_SCALE: begin
          phase_q <= ~phase_q;
          if (phase_q) axis_q <= ~axis_q;
        end
        S_UPD:  cnt_q <= '0;
        S_SCAN: cnt_q <= cnt_q + 6'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        rx_q  <= robot_x_i;
        ry_q  <= robot_y_i;
        rng_q <= range_i;
        ang_q <= heading_i + beam_angle_i;
        hit_q <= !range_i[23] && (range_i[22:0] >= rmin_q) &&
                 (range_i[22:0] <= rmax_q);
      end
      S_TRIG: if (phase_q) begin
        t_q   <= t_cur;
        neg_q <= phase_p[15];
        t2_q  <= prod_q[30:15];
        acc_q <= poly_coef(3'd0);
      end
      S_POLY: if (phase_q) begin
        if (step_q == 3'd4) begin
          if (sh16 < 0) acc_q <= '0;
          else if (sh16 > 44'sd16384) acc_q <= 18'sd16384;
          else acc_q <= 18'(sh16);
        end else begin
          acc_q <= 18'(fshift(prod_q, 5'd15)) + poly_coef(step_q + 3'd1);
        end
      end
      S_RANGE: if (phase_q) begin
        if (axis_q) py_q <= pnt - 26'(org_y_q);
        else px_q <= pnt - 26'(org_x_q);
      end
      S_SCALE: if (phase_q) begin
        if (axis_q) gy_q <= 26'(cell_div);
        else gx_q <= 26'(cell_div);
      end
      S_ROW: if (phase_q) begin
        idx_q <= idx_sum;
        ok_q  <= in_grid && (idx_sum < IdxW'(MaxCells));
      end
      S_UPD: begin
        lo_q  <= lo_clamp;
        mag_q <= lo_mag[10:0];
      end
      default: ;
    endcase
  end

  // occupancy counter over thresholds
  logic [5:0] occ_cnt_q;
  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) occ_cnt_q <= '0;
    else if (state_q == S_SCAN && logit_floor(cnt_q) < mag_q) occ_cnt_q <= occ_cnt_q + 6'd1;
  end

  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_UPD);
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q[AddrW-1:0] : idx_q[AddrW-1:0];
  assign ram_wdata = (state_q == S_CLEAR) ? 12'd0 : lo_clamp;
  assign ram_raddr = idx_q[AddrW-1:0];

  logocc_ram #(.Width(12), .Depth(MaxCells)) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  always_comb begin
    in_bounds_o  = ok_q;
    cell_index_o = ok_q ? 16'(idx_q) : 16'd0;
    log_odds_o   = ok_q ? lo_q : 12'sd0;
    if (!ok_q || {1'b0, mag_q} <= LoUnknown) occupancy_o = -8'sd1;
    else if (!lo_q[11]) occupancy_o = 8'sd50 + 8'(occ_cnt_q);
    else occupancy_o = 8'sd49 - 8'(occ_cnt_q);
  end

  ast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("accepted while busy");
  ast_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped");
  ast_lo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (log_odds_o <= 12'sd1280 && log_odds_o >= -12'sd1280))
    else $error("log-odds out of range");

endmodule

@@ sv/logocc_ram.sv @@
module logocc_ram #(
  parameter int Width = 12,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
